[design/dvfb_pkg.sv]
`default_nettype none
package dvfb_pkg;

   localparam int CountWidth = 17;
   localparam logic [CountWidth-1:0] CountMax = '1;

   typedef enum logic [2:0] {
      CMD_INIT    = 3'd0,
      CMD_SET     = 3'd1,
      CMD_UNSET   = 3'd2,
      CMD_QUERY   = 3'd3,
      CMD_FIND    = 3'd4,
      CMD_SYNC    = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK           = 2'd0,
      ST_INVALID      = 2'd1,
      ST_NOSPACE      = 2'd2,
      ST_INCONSISTENT = 2'd3
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture request fields
      logic read;       // read both maps at current address
      logic rmw;        // set/unset write-back and counts
      logic sweep;      // sweep one word of init, sync or clear pass
      logic sweep_clr;  // clear sweep address
      logic scan_init;  // start scan position
      logic scan_step;  // evaluate read word, advance scan
      logic finish;     // drive result for one cycle
      logic counts_cmd; // apply init or sync to counts
      logic clear;      // fill both maps with ones after reset
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic sweep_last;
      logic scan_done;
   } sts_type;

endpackage
`default_nettype wire

[design/dual_view_free_block_bitmap.sv]
// channel  | ports                                          | direction
// request  | start, req_command/block_number/... (busy is out) | in
// response | rsp_valid, rsp_status ... rsp_future_free_count| out
// config   | csr_we, csr_wdata (num_blocks)                 | in
// set, unset, query: one map read, then a write-back, then the result.
// init, sync: a sweep over every bitmap word (MAX_BLOCKS/WORD_BITS), then the result.
// find free: each block examined takes one map read and one scan step.
// reset is synchronous; a clearing pass over every bitmap word then
// fills both maps with ones while busy is high; counts start at zero.
// busy stays high until the result cycle; results cannot be stalled.
`default_nettype none
module dual_view_free_block_bitmap #(
   parameter int MAX_BLOCKS = 65536,
   parameter int WORD_BITS  = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_command,
   input  wire logic [15:0] req_block_number,
   input  wire logic        req_future_view,
   input  wire logic [15:0] req_start_block,
   input  wire logic        csr_we,
   input  wire logic [16:0] csr_wdata,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic             rsp_is_free,
   output logic [15:0]      rsp_found_block,
   output logic [16:0]      rsp_free_count,
   output logic [16:0]      rsp_future_free_count
);

   dvfb_pkg::ctl_type ctl;
   dvfb_pkg::sts_type sts;

   // sequencer
   dvfb_ctrl u_ctrl (
      .clock, .reset, .start, .req_command, .sts, .busy, .ctl
   );

   // maps, counts and result register
   dvfb_dpath #(.MAX_BLOCKS(MAX_BLOCKS), .WORD_BITS(WORD_BITS)) u_dpath (
      .clock, .reset, .ctl, .sts,
      .req_command, .req_block_number, .req_future_view, .req_start_block,
      .csr_we, .csr_wdata,
      .rsp_valid, .rsp_status, .rsp_is_free, .rsp_found_block,
      .rsp_free_count, .rsp_future_free_count
   );

endmodule
`default_nettype wire

[design/dvfb_ctrl.sv]
`default_nettype none
module dvfb_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [2:0]        req_command,
   input  wire dvfb_pkg::sts_type sts,
   output logic                   busy,
   output dvfb_pkg::ctl_type      ctl
);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b00000001,
      S_READ  = 8'b00000010,
      S_RMW   = 8'b00000100,
      S_SWEEP = 8'b00001000,
      S_SREAD = 8'b00010000,
      S_SCAN  = 8'b00100000,
      S_DONE  = 8'b01000000,
      S_CLEAR = 8'b10000000
   } state_type;

   state_type state_ff, state_in;
   logic [2:0] cmd_ff, cmd_in;

   // command register
   always_ff @(posedge clock) begin
      if (reset) cmd_ff <= dvfb_pkg::CMD_INIT;
      else cmd_ff <= cmd_in;
   end

   always_comb begin
      cmd_in = cmd_ff;
      if (state_ff == S_IDLE && start) cmd_in = req_command;
   end

   // state register, reset starts the clearing pass
   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else state_ff <= state_in;
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      ctl = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.load = 1'b1;
               ctl.sweep_clr = 1'b1;
               ctl.scan_init = 1'b1;
               case (req_command)
                  dvfb_pkg::CMD_INIT, dvfb_pkg::CMD_SYNC: state_in = S_SWEEP;
                  dvfb_pkg::CMD_FIND: state_in = S_SREAD;
                  dvfb_pkg::CMD_SET, dvfb_pkg::CMD_UNSET,
                  dvfb_pkg::CMD_QUERY: state_in = S_READ;
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_READ: begin
            ctl.read = 1'b1;
            state_in = S_RMW;
         end
         S_RMW: begin
            ctl.rmw = 1'b1;
            ctl.finish = 1'b1;
            state_in = S_IDLE;
         end
         S_SWEEP: begin
            ctl.sweep = 1'b1;
            if (sts.sweep_last) begin
               ctl.counts_cmd = 1'b1;
               state_in = S_DONE;
            end
         end
         S_SREAD: begin
            ctl.read = 1'b1;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            ctl.scan_step = 1'b1;
            if (sts.scan_done) state_in = S_DONE;
            else state_in = S_SREAD;
         end
         S_DONE: begin
            ctl.finish = 1'b1;
            state_in = S_IDLE;
         end
         S_CLEAR: begin
            ctl.sweep = 1'b1;
            ctl.clear = 1'b1;
            if (sts.sweep_last) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   // a command runs only from idle
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.load |-> !busy) else $error("load while busy");
   a_finish_to_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.finish |=> state_ff == S_IDLE) else $error("finish not followed by idle");
   a_scan_after_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> $past(state_ff) == S_SREAD) else $error("scan w/o read");
   a_cmd_stable: assert property (@(posedge clock) disable iff (reset)
      busy && $past(busy) |-> $stable(cmd_ff)) else $error("cmd changed");

endmodule
`default_nettype wire

[design/dvfb_dpath.sv]
`default_nettype none
module dvfb_dpath #(
   parameter int MAX_BLOCKS = 65536,
   parameter int WORD_BITS  = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire dvfb_pkg::ctl_type ctl,
   output dvfb_pkg::sts_type      sts,
   input  wire logic [2:0]        req_command,
   input  wire logic [15:0]       req_block_number,
   input  wire logic              req_future_view,
   input  wire logic [15:0]       req_start_block,
   input  wire logic              csr_we,
   input  wire logic [16:0]       csr_wdata,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_status,
   output logic                   rsp_is_free,
   output logic [15:0]            rsp_found_block,
   output logic [16:0]            rsp_free_count,
   output logic [16:0]            rsp_future_free_count
);

   localparam int Words = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW = (Words > 1) ? $clog2(Words) : 1;
   localparam int BW = $clog2(WORD_BITS);
   localparam int CW = dvfb_pkg::CountWidth;

   logic [WORD_BITS-1:0] cons_mem [Words];
   logic [WORD_BITS-1:0] fut_mem  [Words];
   logic [WORD_BITS-1:0] cons_rd_ff, fut_rd_ff, sync_rd_ff;
   logic [AW-1:0]        sync_addr_ff;
   logic                 sync_wr_ff;

   logic [2:0]    cmd_ff;
   logic [15:0]   blk_ff, start_ff, pos_ff, pos_in;
   logic          view_ff;
   logic [CW-1:0] nb_ff, ccnt_ff, fcnt_ff, ccnt_in, fcnt_in, exam_ff, exam_in;
   logic [AW-1:0] sw_ff, sw_in;
   logic [1:0]    st_ff, st_in;
   logic          free_ff, free_in, vld_ff;
   logic [15:0]   found_ff, found_in;

   // request capture and config
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff   <= req_command;
         blk_ff   <= req_block_number;
         view_ff  <= req_future_view;
         start_ff <= req_start_block;
      end
      if (reset) nb_ff <= CW'(65536);
      else if (csr_we) nb_ff <= csr_wdata;
   end

   // word address: either the request block or the scan position
   logic [15:0] addr_blk;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [BW-1:0] bit_sel;
   assign addr_blk = (cmd_ff == dvfb_pkg::CMD_FIND) ? pos_ff : blk_ff;
   assign rd_addr  = AW'(32'(addr_blk) / WORD_BITS);
   assign bit_sel  = BW'(32'(addr_blk) % WORD_BITS);
   assign wr_addr  = ctl.sweep ? sw_ff : rd_addr;

   function automatic logic blk_ok(input logic [15:0] b, input logic [CW-1:0] n);
      blk_ok = (CW'(b) < n) && (32'(b) < MAX_BLOCKS);
   endfunction

   logic ok, cb, fb, do_set, do_unset;
   assign ok = blk_ok(addr_blk, nb_ff);
   assign cb = cons_rd_ff[bit_sel];
   assign fb = fut_rd_ff[bit_sel];
   assign do_set   = ctl.rmw && cmd_ff == dvfb_pkg::CMD_SET && ok && !cb && !fb;
   assign do_unset = ctl.rmw && cmd_ff == dvfb_pkg::CMD_UNSET && ok && cb && fb;

   // bitmap memories; sync copies a word in the cycle after reading it
   always_ff @(posedge clock) begin
      if (ctl.read) begin
         cons_rd_ff <= cons_mem[rd_addr];
         fut_rd_ff  <= fut_mem[rd_addr];
      end
      if (ctl.sweep) sync_rd_ff <= fut_mem[sw_ff];
      if (ctl.sweep && (ctl.clear || cmd_ff == dvfb_pkg::CMD_INIT)) begin
         cons_mem[wr_addr] <= '1;
         fut_mem[wr_addr]  <= '1;
      end else if (do_set) begin
         fut_mem[wr_addr] <= fut_rd_ff | (WORD_BITS'(1) << bit_sel);
      end else if (do_unset) begin
         cons_mem[wr_addr] <= cons_rd_ff & ~(WORD_BITS'(1) << bit_sel);
         fut_mem[wr_addr]  <= fut_rd_ff & ~(WORD_BITS'(1) << bit_sel);
      end
      if (sync_wr_ff) cons_mem[sync_addr_ff] <= sync_rd_ff;
   end

   // sync copy write stage
   always_ff @(posedge clock) begin
      if (reset) sync_wr_ff <= 1'b0;
      else sync_wr_ff <= ctl.sweep && !ctl.clear && cmd_ff == dvfb_pkg::CMD_SYNC;
      sync_addr_ff <= sw_ff;
   end

   // sweep address
   always_ff @(posedge clock) begin
      if (reset) sw_ff <= '0;
      else sw_ff <= sw_in;
   end
   assign sw_in = ctl.sweep_clr ? '0 : (ctl.sweep ? sw_ff + AW'(1) : sw_ff);
   assign sts.sweep_last = (32'(sw_ff) == Words - 1);

   // scan: wrap and exhaustion; stepping past block 65535 leaves the map
   logic [15:0] nxt;
   logic wrap, ovf, step_done;
   assign wrap = (nb_ff >= CW'(2)) && (CW'(pos_ff) >= nb_ff - CW'(2));
   assign ovf  = !wrap && (pos_ff == 16'hFFFF);
   assign nxt  = wrap ? 16'd1 : pos_ff + 16'd1;
   assign step_done = (ccnt_ff == '0) || !ok || cb || ovf || (nxt == start_ff) ||
                      (exam_ff + CW'(1) >= nb_ff);
   assign sts.scan_done = step_done;

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      exam_ff <= exam_in;
   end
   always_comb begin
      pos_in = pos_ff;
      exam_in = exam_ff;
      if (ctl.scan_init) begin
         pos_in = req_start_block;
         exam_in = '0;
      end else if (ctl.scan_step) begin
         pos_in = nxt;
         exam_in = exam_ff + CW'(1);
      end
   end

   // counts and result
   always_ff @(posedge clock) begin
      if (reset) begin
         ccnt_ff <= '0;
         fcnt_ff <= '0;
         vld_ff  <= 1'b0;
      end else begin
         ccnt_ff <= ccnt_in;
         fcnt_ff <= fcnt_in;
         vld_ff  <= ctl.finish;
      end
      st_ff    <= st_in;
      free_ff  <= free_in;
      found_ff <= found_in;
   end

   always_comb begin
      ccnt_in = ccnt_ff;
      fcnt_in = fcnt_ff;
      if (ctl.counts_cmd) begin
         if (cmd_ff == dvfb_pkg::CMD_INIT) begin
            ccnt_in = nb_ff;
            fcnt_in = nb_ff;
         end else begin
            ccnt_in = fcnt_ff;
         end
      end else if (do_set) begin
         if (fcnt_ff != dvfb_pkg::CountMax) fcnt_in = fcnt_ff + CW'(1);
      end else if (do_unset) begin
         if (ccnt_ff != '0) ccnt_in = ccnt_ff - CW'(1);
         if (fcnt_ff != '0) fcnt_in = fcnt_ff - CW'(1);
      end
   end

   always_comb begin
      st_in = st_ff;
      free_in = free_ff;
      found_in = found_ff;
      if (ctl.load) begin
         st_in = dvfb_pkg::ST_OK;
         free_in = 1'b0;
         found_in = '0;
         if (req_command > dvfb_pkg::CMD_SYNC) st_in = dvfb_pkg::ST_INVALID;
      end else if (ctl.rmw) begin
         case (cmd_ff)
            dvfb_pkg::CMD_SET: if (!ok || cb || fb) st_in = dvfb_pkg::ST_INVALID;
            dvfb_pkg::CMD_UNSET: if (!ok || !cb || !fb) st_in = dvfb_pkg::ST_INVALID;
            default: begin
               if (!ok) st_in = dvfb_pkg::ST_INVALID;
               else free_in = view_ff ? fb : cb;
            end
         endcase
      end else if (ctl.scan_step) begin
         if (ccnt_ff == '0) st_in = dvfb_pkg::ST_NOSPACE;
         else if (!ok) st_in = dvfb_pkg::ST_INVALID;
         else if (cb) found_in = pos_ff;
         else if (ovf && (exam_ff + CW'(1) < nb_ff)) st_in = dvfb_pkg::ST_INVALID;
         else if (step_done) st_in = dvfb_pkg::ST_INCONSISTENT;
      end
   end

   // rmw results leave with finish in the same cycle, so feed next values
   assign rsp_valid             = vld_ff;
   assign rsp_status            = st_ff;
   assign rsp_is_free           = free_ff;
   assign rsp_found_block       = found_ff;
   assign rsp_free_count        = ccnt_ff;
   assign rsp_future_free_count = fcnt_ff;

   // set and unset move the counts by one
   a_set_count: assert property (@(posedge clock) disable iff (reset)
      do_set && fcnt_ff != dvfb_pkg::CountMax |=> fcnt_ff == $past(fcnt_ff) + CW'(1))
      else $error("set count");
   a_unset_cons: assert property (@(posedge clock) disable iff (reset)
      do_unset && ccnt_ff != '0 |=> ccnt_ff == $past(ccnt_ff) - CW'(1))
      else $error("unset count");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(do_set && do_unset)) else $error("set and unset");

endmodule
`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
module testbench;

   localparam int MaxBlocks = 65536;
   localparam logic [2:0] CmdBadLow = 3'd6;
   localparam logic [2:0] CmdBadHigh = 3'd7;

   // one expected response word
   typedef struct {
      dvfb_pkg::status_type status;
      logic                 is_free;
      logic [15:0]          found_block;
      logic [16:0]          free_count;
      logic [16:0]          future_free_count;
   } bitmap_rsp_type;

   // shadow of both free maps and the expected response queue
   class bitmap_scoreboard;
      bit               cons_map[MaxBlocks];
      bit               fut_map[MaxBlocks];
      logic [16:0]      cons_count;
      logic [16:0]      fut_count;
      logic [16:0]      num_blocks;
      bitmap_rsp_type   rsp_q[$];
      int               errors;

      function void power_up();
         foreach (cons_map[i]) begin
            cons_map[i] = 1'b1;
            fut_map[i] = 1'b1;
         end
         cons_count = '0;
         fut_count = '0;
         num_blocks = 17'd65536;
         errors = 0;
      endfunction

      function bit in_range(int b);
         return b < num_blocks && b < MaxBlocks;
      endfunction

      // scan of the conservative map with wrap inside 1..n-2
      function dvfb_pkg::status_type scan_free(int first, output logic [15:0] hit);
         int blk;
         int seen;
         blk = first;
         seen = 0;
         hit = '0;
         if (cons_count == 0) return dvfb_pkg::ST_NOSPACE;
         forever begin
            if (!in_range(blk)) return dvfb_pkg::ST_INVALID;
            if (cons_map[blk]) begin
               hit = blk[15:0];
               return dvfb_pkg::ST_OK;
            end
            if (num_blocks >= 2 && blk >= num_blocks - 2) blk = 1;
            else blk++;
            if (blk == first) return dvfb_pkg::ST_INCONSISTENT;
            seen++;
            if (seen >= num_blocks) return dvfb_pkg::ST_INCONSISTENT;
         end
      endfunction

      // note an accepted command word and queue its response
      function void note_command(logic [2:0] cmd, logic [15:0] blk, logic view,
                                 logic [15:0] first);
         bitmap_rsp_type r;
         r.status = dvfb_pkg::ST_OK;
         r.is_free = 1'b0;
         r.found_block = '0;
         case (cmd)
            dvfb_pkg::CMD_INIT: begin
               foreach (cons_map[i]) begin
                  cons_map[i] = 1'b1;
                  fut_map[i] = 1'b1;
               end
               cons_count = num_blocks;
               fut_count = num_blocks;
            end
            dvfb_pkg::CMD_SET: begin
               if (!in_range(blk) || cons_map[blk] || fut_map[blk]) begin
                  r.status = dvfb_pkg::ST_INVALID;
               end else begin
                  fut_map[blk] = 1'b1;
                  if (fut_count != dvfb_pkg::CountMax) fut_count++;
               end
            end
            dvfb_pkg::CMD_UNSET: begin
               if (!in_range(blk) || !cons_map[blk] || !fut_map[blk]) begin
                  r.status = dvfb_pkg::ST_INVALID;
               end else begin
                  cons_map[blk] = 1'b0;
                  fut_map[blk] = 1'b0;
                  if (cons_count != 0) cons_count--;
                  if (fut_count != 0) fut_count--;
               end
            end
            dvfb_pkg::CMD_QUERY: begin
               if (!in_range(blk)) r.status = dvfb_pkg::ST_INVALID;
               else r.is_free = view ? fut_map[blk] : cons_map[blk];
            end
            dvfb_pkg::CMD_FIND: begin
               r.status = scan_free(first, r.found_block);
               if (r.status != dvfb_pkg::ST_OK) r.found_block = '0;
            end
            dvfb_pkg::CMD_SYNC: begin
               cons_map = fut_map;
               cons_count = fut_count;
            end
            default: r.status = dvfb_pkg::ST_INVALID;
         endcase
         r.free_count = cons_count;
         r.future_free_count = fut_count;
         rsp_q.push_back(r);
      endfunction

      // compare one response word with the oldest expectation
      function void check_response(bitmap_rsp_type got);
         bitmap_rsp_type e;
         if (rsp_q.size() == 0) begin
            $error("unexpected response word, status %0d", got.status);
            errors++;
            return;
         end
         e = rsp_q.pop_front();
         if (got.status !== e.status) begin
            $error("status: expected %0d actual %0d", e.status, got.status);
            errors++;
         end
         if (got.is_free !== e.is_free) begin
            $error("is_free: expected %0d actual %0d", e.is_free, got.is_free);
            errors++;
         end
         if (got.found_block !== e.found_block) begin
            $error("found_block: expected %0d actual %0d", e.found_block,
                   got.found_block);
            errors++;
         end
         if (got.free_count !== e.free_count) begin
            $error("free_count: expected %0d actual %0d", e.free_count,
                   got.free_count);
            errors++;
         end
         if (got.future_free_count !== e.future_free_count) begin
            $error("future_free_count: expected %0d actual %0d",
                   e.future_free_count, got.future_free_count);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_command;
   logic [15:0] req_block_number;
   logic        req_future_view;
   logic [15:0] req_start_block;
   logic        csr_we;
   logic [16:0] csr_wdata;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic        rsp_is_free;
   logic [15:0] rsp_found_block;
   logic [16:0] rsp_free_count;
   logic [16:0] rsp_future_free_count;

   bitmap_scoreboard bitmap_sb;
   int burst_left;

   dual_view_free_block_bitmap u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_command           (req_command),
      .req_block_number      (req_block_number),
      .req_future_view       (req_future_view),
      .req_start_block       (req_start_block),
      .csr_we                (csr_we),
      .csr_wdata             (csr_wdata),
      .rsp_valid             (rsp_valid),
      .rsp_status            (rsp_status),
      .rsp_is_free           (rsp_is_free),
      .rsp_found_block       (rsp_found_block),
      .rsp_free_count        (rsp_free_count),
      .rsp_future_free_count (rsp_future_free_count)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // response monitor
   always @(posedge clock) begin
      bitmap_rsp_type got;
      if (!reset && rsp_valid) begin
         got.status = dvfb_pkg::status_type'(rsp_status);
         got.is_free = rsp_is_free;
         got.found_block = rsp_found_block;
         got.free_count = rsp_free_count;
         got.future_free_count = rsp_future_free_count;
         bitmap_sb.check_response(got);
      end
   end

   // send one command word; start stays high until accepted
   task automatic send_word(logic [2:0] cmd, logic [15:0] blk, logic view,
                            logic [15:0] first);
      bit taken;
      // bursts with random gaps
      if (burst_left == 0) begin
         repeat ($urandom_range(0, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      @(negedge clock);
      start = 1'b1;
      req_command = cmd;
      req_block_number = blk;
      req_future_view = view;
      req_start_block = first;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         if (!busy) begin
            taken = 1'b1;
            bitmap_sb.note_command(cmd, blk, view, first);
         end
      end
      @(negedge clock);
      start = 1'b0;
      req_command = 3'($urandom);
      req_block_number = 16'($urandom);
      req_future_view = 1'($urandom);
      req_start_block = 16'($urandom);
   endtask

   // wait for idle, then write the block count register
   task automatic write_num_blocks(logic [16:0] value);
      while (bitmap_sb.rsp_q.size() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_we = 1'b1;
      csr_wdata = value;
      bitmap_sb.num_blocks = value;
      @(negedge clock);
      csr_we = 1'b0;
      csr_wdata = 17'($urandom);
   endtask

   // block number near the configured range, sometimes anywhere
   function automatic logic [15:0] pick_block(int n);
      if ($urandom_range(0, 9) == 0 || n > MaxBlocks - 4) return 16'($urandom);
      return 16'($urandom_range(0, n + 1));
   endfunction

   task automatic random_phase(int n, int items, bit with_init);
      logic [2:0] cmd;
      int pick;
      write_num_blocks(n[16:0]);
      if (with_init) send_word(dvfb_pkg::CMD_INIT, '0, 1'b0, '0);
      repeat (items) begin
         pick = $urandom_range(0, 99);
         if (pick < 3) cmd = dvfb_pkg::CMD_INIT;
         else if (pick < 25) cmd = dvfb_pkg::CMD_SET;
         else if (pick < 50) cmd = dvfb_pkg::CMD_UNSET;
         else if (pick < 68) cmd = dvfb_pkg::CMD_QUERY;
         else if (pick < 86) cmd = dvfb_pkg::CMD_FIND;
         else if (pick < 97) cmd = dvfb_pkg::CMD_SYNC;
         else cmd = 3'($urandom_range(CmdBadLow, CmdBadHigh));
         // large maps: keep the slow sweeps rare
         if (n > 1000 && (cmd == dvfb_pkg::CMD_INIT || cmd == dvfb_pkg::CMD_SYNC) &&
             pick % 3 != 0)
            cmd = dvfb_pkg::CMD_QUERY;
         send_word(cmd, pick_block(n), 1'($urandom), pick_block(n));
      end
   endtask

   // stimulus
   initial begin
      bitmap_sb = new();
      bitmap_sb.power_up();
      burst_left = 0;
      reset = 1'b1;
      start = 1'b0;
      req_command = dvfb_pkg::CMD_INIT;
      req_block_number = '0;
      req_future_view = 1'b0;
      req_start_block = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // largest map, edges of the block fields
      write_num_blocks(17'd65536);
      send_word(dvfb_pkg::CMD_INIT, '0, 1'b0, '0);
      send_word(dvfb_pkg::CMD_QUERY, 16'd0, 1'b0, '0);
      send_word(dvfb_pkg::CMD_QUERY, 16'hFFFF, 1'b1, 16'hFFFF);
      send_word(dvfb_pkg::CMD_SET, 16'd5, 1'b0, '0);
      send_word(dvfb_pkg::CMD_UNSET, 16'd0, 1'b0, '0);
      send_word(dvfb_pkg::CMD_UNSET, 16'd0, 1'b0, '0);
      send_word(dvfb_pkg::CMD_SET, 16'd0, 1'b0, '0);
      send_word(dvfb_pkg::CMD_QUERY, 16'd0, 1'b1, '0);
      send_word(dvfb_pkg::CMD_QUERY, 16'd0, 1'b0, '0);
      send_word(dvfb_pkg::CMD_FIND, '0, 1'b0, 16'd0);
      send_word(dvfb_pkg::CMD_FIND, '0, 1'b0, 16'hFFFF);
      send_word(dvfb_pkg::CMD_SYNC, '0, 1'b0, '0);
      send_word(CmdBadLow, 16'hFFFF, 1'b1, 16'hFFFF);
      send_word(CmdBadHigh, '0, 1'b0, '0);

      // smallest map: empty count gives no space
      write_num_blocks(17'd3);
      send_word(dvfb_pkg::CMD_INIT, '0, 1'b0, '0);
      send_word(dvfb_pkg::CMD_UNSET, 16'd0, 1'b0, '0);
      send_word(dvfb_pkg::CMD_UNSET, 16'd1, 1'b0, '0);
      send_word(dvfb_pkg::CMD_UNSET, 16'd2, 1'b0, '0);
      send_word(dvfb_pkg::CMD_UNSET, 16'd3, 1'b0, '0);
      send_word(dvfb_pkg::CMD_FIND, '0, 1'b0, 16'd0);
      send_word(dvfb_pkg::CMD_SET, 16'd1, 1'b0, '0);
      send_word(dvfb_pkg::CMD_SYNC, '0, 1'b0, '0);
      send_word(dvfb_pkg::CMD_FIND, '0, 1'b0, 16'd2);

      // scan that comes back to its start
      write_num_blocks(17'd4);
      send_word(dvfb_pkg::CMD_INIT, '0, 1'b0, '0);
      send_word(dvfb_pkg::CMD_UNSET, 16'd1, 1'b0, '0);
      send_word(dvfb_pkg::CMD_UNSET, 16'd2, 1'b0, '0);
      send_word(dvfb_pkg::CMD_FIND, '0, 1'b0, 16'd1);
      send_word(dvfb_pkg::CMD_FIND, '0, 1'b0, 16'd4);

      // random phases; two of them run without an init
      random_phase(17, 80, 1'b1);
      random_phase(40, 80, 1'b1);
      random_phase(3, 50, 1'b1);
      random_phase(65536, 40, 1'b0);
      random_phase(100, 90, 1'b1);
      random_phase(5, 60, 1'b1);
      random_phase(65536, 30, 1'b1);
      random_phase(9, 70, 1'b0);

      while (bitmap_sb.rsp_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (bitmap_sb.errors == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

   // watchdog
   initial begin
      #40ms;
      $display("Regression FAIL");
      $finish;
   end

endmodule

[sim.f]
design/dvfb_pkg.sv
design/dvfb_ctrl.sv
design/dvfb_dpath.sv
design/dual_view_free_block_bitmap.sv
tb/sv/testbench.sv
